[sv/timeline_playback_sequencer_macros.svh]
// Assertion macros for the timeline playback sequencer.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef TIMELINE_PLAYBACK_SEQUENCER_MACROS_SVH
`define TIMELINE_PLAYBACK_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF

// Antecedent implies consequent in the same cycle.
`define TPS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define TPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TPS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define TPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[sv/tps_pkg.sv]
// Shared types and constants for the timeline playback sequencer.
// No dependencies; imported by the event table and the top level.
`timescale 1ns / 1ps

package tps_pkg;

    // Default depth of the event table.
    localparam int unsigned TPS_EVENTS = 16;

    // Fixed field widths.
    localparam int unsigned POS_W   = 32;
    localparam int unsigned DELTA_W = 24;
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned CFG_IDX_W = 2;

    // Reset value of the end time: 1.0 in 16.16 fixed point.
    localparam logic [POS_W-1:0] END_TIME_RST = 32'h0001_0000;

    // Item kinds.
    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_COMMAND = 2'd1,
        KIND_EVWRITE = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    // Control commands.
    typedef enum logic [2:0] {
        CMD_PLAY       = 3'd0,
        CMD_PLAY_START = 3'd1,
        CMD_STOP       = 3'd2,
        CMD_REVERSE    = 3'd3,
        CMD_REV_END    = 3'd4,
        CMD_SET_FRAME  = 3'd5,
        CMD_RESET      = 3'd6,
        CMD_NONE       = 3'd7
    } t_command;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_END_TIME    = 2'd0,
        CFG_LOOP_ENABLE = 2'd1,
        CFG_SWING       = 2'd2,
        CFG_EVENT_COUNT = 2'd3
    } t_cfg_idx;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_SCAN = 3'b100
    } t_state;

endpackage

[sv/tps_event_mem.sv]
// Event time table: a single-port-write, single-port-read synchronous memory.
// Depends on tps_pkg for the position width and the default depth.
`timescale 1ns / 1ps

module tps_event_mem
    import tps_pkg::*;
#(
    parameter int unsigned EVENTS = TPS_EVENTS,
    parameter int unsigned IDX_W  = (EVENTS > 1) ? $clog2(EVENTS) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [POS_W-1:0] i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [POS_W-1:0] o_rdata
);

    logic [POS_W-1:0] r_mem [EVENTS];
    logic [POS_W-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/timeline_playback_sequencer.sv]
// Timeline playback sequencer: position timer with clamping, looping and event marks.
// Depends on tps_pkg, tps_event_mem and timeline_playback_sequencer_macros.svh.
// Commands, event writes, unknown kinds and idle ticks give a single status beat,
// which appears the cycle after acceptance; busy never rises. A playing tick adds,
// clamps, makes one table read per event to scan through the single read port, then
// gives the status beat. Reset (synchronous, active low) restores the state and the
// configuration and control registers; the payload registers and the table are not
// cleared. The receiver cannot stall: every result beat lasts exactly one cycle.
`timescale 1ns / 1ps
`include "timeline_playback_sequencer_macros.svh"

module timeline_playback_sequencer
    import tps_pkg::*;
#(
    parameter int unsigned EVENTS = TPS_EVENTS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [POS_W-1:0]     i_cfg_wdata,
    // Command side
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_kind,
    input  logic [DELTA_W-1:0]   i_time_delta,
    input  logic [2:0]           i_command,
    input  logic [POS_W-1:0]     i_frame_value,
    input  logic [SLOT_W-1:0]    i_event_slot,
    input  logic [POS_W-1:0]     i_event_time,
    // Result side
    output logic                 o_strobe,
    output logic                 o_event_fired,
    output logic [3:0]           o_fired_index,
    output logic [POS_W-1:0]     o_position,
    output logic                 o_finished,
    output logic                 o_playing,
    output logic                 o_forward,
    output logic                 o_reached_start,
    output logic                 o_last
);

    localparam int unsigned IDX_W = (EVENTS > 1) ? $clog2(EVENTS) : 1;
    localparam int unsigned CNT_W = $clog2(EVENTS + 1);

    // Configuration registers
    logic [POS_W-1:0]   r_end_time;
    logic               r_loop_en;
    logic               r_swing_en;
    logic [COUNT_W-1:0] r_event_count;

    // Playback state
    t_state             r_state, n_state;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic               r_play, n_play;
    logic               r_fwd, n_fwd;
    logic               r_start_hit, n_start_hit;

    // Tick working registers
    logic [POS_W:0]     r_sum, n_sum;
    logic [POS_W-1:0]   r_prev, n_prev;
    logic [POS_W-1:0]   r_new, n_new;
    logic               r_fin, n_fin;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_rd_vld, n_rd_vld;
    logic [CNT_W-1:0]   r_rd_idx, n_rd_idx;

    // Output registers
    logic               r_strobe, n_strobe;
    logic               r_ev_fired, n_ev_fired;
    logic [3:0]         r_fired_idx, n_fired_idx;
    logic               r_out_fin, n_out_fin;
    logic               r_last, n_last;

    // Table access
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [IDX_W-1:0]   mem_raddr;
    logic [POS_W-1:0]   mem_rdata;

    logic               accept;
    logic               slot_ok;
    logic [IDX_W+SLOT_W-1:0] slot_ext;
    logic [8:0]         count_ext;
    logic [8:0]         count_lim;
    logic [CNT_W+3:0]   rd_idx_ext;
    logic               le_zero;
    logic               ge_end;
    logic               issue;
    logic               hit;
    logic               fwd_loop;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_time    <= END_TIME_RST;
            r_loop_en     <= 1'b0;
            r_swing_en    <= 1'b0;
            r_event_count <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_END_TIME:    r_end_time    <= i_cfg_wdata;
                CFG_LOOP_ENABLE: r_loop_en     <= i_cfg_wdata[0];
                CFG_SWING:       r_swing_en    <= i_cfg_wdata[0];
                CFG_EVENT_COUNT: r_event_count <= i_cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Event table write address and range check.
    assign slot_ext  = (IDX_W + SLOT_W)'(i_event_slot);
    assign slot_ok   = ({5'd0, i_event_slot} < 9'(EVENTS));
    assign mem_waddr = slot_ext[IDX_W-1:0];
    assign mem_we    = accept && (t_kind'(i_kind) == KIND_EVWRITE) && slot_ok;
    assign mem_raddr = r_idx[IDX_W-1:0];

    // Number of entries to scan, limited to the table depth.
    assign count_ext = 9'(r_event_count);
    assign count_lim = (count_ext < 9'(EVENTS)) ? count_ext : 9'(EVENTS);

    // Clamp tests on the registered sum: a borrow means the position went negative.
    assign le_zero = (r_sum == '0) || (!r_fwd && r_sum[POS_W]);
    assign ge_end  = (r_sum >= {1'b0, r_end_time});
    assign fwd_loop = r_swing_en ? !r_fwd : r_fwd;

    // Scan control: one table read a cycle, compare on the following cycle.
    assign issue      = (r_state == S_SCAN) && (r_idx < r_cnt);
    assign hit        = (r_prev <= mem_rdata) && (mem_rdata <= r_new);
    assign rd_idx_ext = (CNT_W + 4)'(r_rd_idx);

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_play      = r_play;
        n_fwd       = r_fwd;
        n_start_hit = r_start_hit;
        n_sum       = r_sum;
        n_prev      = r_prev;
        n_new       = r_new;
        n_fin       = r_fin;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_strobe    = 1'b0;
        n_ev_fired  = 1'b0;
        n_fired_idx = '0;
        n_out_fin   = 1'b0;
        n_last      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if ((t_kind'(i_kind) == KIND_TICK) && r_play) begin
                        // Playing tick: start the add, the status beat comes later.
                        n_prev = r_pos;
                        if (r_fwd) begin
                            n_sum = {1'b0, r_pos} + (POS_W + 1)'(i_time_delta);
                        end else begin
                            n_sum = {1'b0, r_pos} - (POS_W + 1)'(i_time_delta);
                        end
                        n_state = S_CALC;
                    end else begin
                        if (t_kind'(i_kind) == KIND_COMMAND) begin
                            case (t_command'(i_command))
                                CMD_PLAY: begin
                                    n_fwd  = 1'b1;
                                    n_play = 1'b1;
                                end
                                CMD_PLAY_START: begin
                                    n_pos  = '0;
                                    n_fwd  = 1'b1;
                                    n_play = 1'b1;
                                end
                                CMD_STOP: begin
                                    n_play = 1'b0;
                                end
                                CMD_REVERSE: begin
                                    n_fwd  = 1'b0;
                                    n_play = 1'b1;
                                end
                                CMD_REV_END: begin
                                    n_pos  = r_end_time;
                                    n_fwd  = 1'b0;
                                    n_play = 1'b1;
                                end
                                CMD_SET_FRAME: begin
                                    n_pos = i_frame_value;
                                end
                                CMD_RESET: begin
                                    n_pos  = '0;
                                    n_fwd  = 1'b1;
                                    n_play = 1'b0;
                                end
                                default: ;
                            endcase
                        end
                        // Single status beat for everything but a playing tick.
                        n_strobe = 1'b1;
                        n_last   = 1'b1;
                    end
                end
            end

            S_CALC: begin
                // Clamp, then commit the state; the loop reload follows the clamp.
                n_fin = 1'b0;
                if (le_zero) begin
                    n_new       = '0;
                    n_play      = 1'b0;
                    n_fin       = 1'b1;
                    n_start_hit = 1'b1;
                end else if (ge_end) begin
                    n_new  = r_end_time;
                    n_play = 1'b0;
                    n_fin  = 1'b1;
                end else begin
                    n_new = r_sum[POS_W-1:0];
                end
                n_pos = n_new;
                if (n_fin && r_loop_en) begin
                    n_fwd  = fwd_loop;
                    n_pos  = fwd_loop ? '0 : r_end_time;
                    n_play = 1'b1;
                end
                n_cnt   = CNT_W'(count_lim);
                n_idx   = '0;
                n_state = S_SCAN;
            end

            S_SCAN: begin
                if (issue) begin
                    n_idx    = r_idx + 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx;
                end
                if (r_rd_vld) begin
                    // Event beat for an entry inside the window.
                    if (hit) begin
                        n_strobe    = 1'b1;
                        n_ev_fired  = 1'b1;
                        n_fired_idx = rd_idx_ext[3:0];
                        n_out_fin   = r_fin;
                    end
                end else if (!issue) begin
                    // Scan over: closing status beat.
                    n_strobe  = 1'b1;
                    n_out_fin = r_fin;
                    n_last    = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_play      <= 1'b0;
            r_fwd       <= 1'b1;
            r_start_hit <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_strobe    <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_play      <= n_play;
            r_fwd       <= n_fwd;
            r_start_hit <= n_start_hit;
            r_rd_vld    <= n_rd_vld;
            r_strobe    <= n_strobe;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_sum       <= n_sum;
        r_prev      <= n_prev;
        r_new       <= n_new;
        r_fin       <= n_fin;
        r_rd_idx    <= n_rd_idx;
        r_ev_fired  <= n_ev_fired;
        r_fired_idx <= n_fired_idx;
        r_out_fin   <= n_out_fin;
        r_last      <= n_last;
    end

    tps_event_mem #(
        .EVENTS (EVENTS),
        .IDX_W  (IDX_W)
    ) u_event_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_event_time),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Every beat carries the state left by the whole item.
    assign o_strobe        = r_strobe;
    assign o_event_fired   = r_ev_fired;
    assign o_fired_index   = r_fired_idx;
    assign o_position      = r_pos;
    assign o_finished      = r_out_fin;
    assign o_playing       = r_play;
    assign o_forward       = r_fwd;
    assign o_reached_start = r_start_hit;
    assign o_last          = r_last;

    // An event beat is never the final beat of its item.
    `TPS_ASSERT_IMPL(a_event_not_last, i_clk, i_rst_n, o_strobe && o_event_fired, !o_last, "event beat marked last")
    // An event beat always has a status beat still to come.
    `TPS_ASSERT_IMPL(a_event_busy, i_clk, i_rst_n, o_strobe && o_event_fired, busy, "event beat after scan end")
    // Table reads are only in flight during the scan.
    `TPS_ASSERT_IMPL(a_read_in_scan, i_clk, i_rst_n, r_rd_vld, r_state == S_SCAN, "read outside scan")
    // The clamp stage always moves on to the scan.
    `TPS_ASSERT_NEXT(a_calc_to_scan, i_clk, i_rst_n, r_state == S_CALC, r_state == S_SCAN, "clamp stage stuck")

endmodule
